/* hdl/battery_level_gauge_core_macros.svh */
// assertion macros for the battery level gauge
`ifndef BATTERY_LEVEL_GAUGE_CORE_MACROS_SVH
`define BATTERY_LEVEL_GAUGE_CORE_MACROS_SVH

`ifndef SYNTH
`define BLG_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("blg assertion failed");
`define BLG_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("blg assertion failed");
`else
`define BLG_ASSERT_IMP(lbl, ante, cons)
`define BLG_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

/* hdl/blg_pkg.sv */
package blg_pkg;

    localparam int WINDOW_DEFAULT = 256;

    localparam int SAMPLE_W = 10;
    localparam int LEVEL_W  = 16;
    localparam int GAIN_W   = 24;
    localparam int PCT_W    = 15;
    localparam int WHOLE_W  = 7;
    localparam int BAND_W   = 3;
    localparam int ACT_W    = 2;
    localparam int CIDX_W   = 2;
    localparam int CDATA_W  = 24;

    localparam logic [ACT_W-1:0] ACT_STORE = 2'd0;
    localparam logic [ACT_W-1:0] ACT_EVAL  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_PRIME = 2'd2;

    localparam logic [CIDX_W-1:0] CFG_DEAD = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_FULL = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_GAIN = 2'd2;
    localparam logic [CIDX_W-1:0] CFG_HYST = 2'd3;

    localparam logic [LEVEL_W-1:0] DEAD_RESET = 16'd53174;
    localparam logic [LEVEL_W-1:0] FULL_RESET = 16'd60515;
    localparam logic [GAIN_W-1:0]  GAIN_RESET = 24'd228541;
    localparam logic [PCT_W-1:0]   HYST_RESET = 15'd128;

    localparam logic [PCT_W-1:0]   PCT_MAX    = 15'd25600;
    localparam logic [WHOLE_W-1:0] WHOLE_NONE = 7'd127;
    localparam logic [WHOLE_W-1:0] WHOLE_MAX  = 7'd100;

    function automatic logic [BAND_W-1:0] band_of(input logic [WHOLE_W-1:0] whole);
        logic [BAND_W-1:0] b;
        if (whole > WHOLE_MAX)
            b = 3'd0;
        else if (whole < 7'd20)
            b = 3'd1;
        else if (whole < 7'd40)
            b = 3'd2;
        else if (whole < 7'd60)
            b = 3'd3;
        else if (whole < 7'd80)
            b = 3'd4;
        else
            b = 3'd5;
        return b;
    endfunction

endpackage

/* hdl/battery_level_gauge_core.sv */
// path: an accepted input transaction passes stages a, b, c and the output register
// throughput: one transaction per cycle when out_stall is low; window sum, average,
//   percent multiply and hysteresis each sit in a register stage of their own
// reset: rst_n clears window state, held percent, reported percent (none) and config
//   to defaults; the sample memory is not cleared and needs no clearing pass
module battery_level_gauge_core #(
    parameter int WINDOW = blg_pkg::WINDOW_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,

    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [blg_pkg::CIDX_W-1:0]       cfg_index,
    input  logic [blg_pkg::CDATA_W-1:0]      cfg_data,

    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [blg_pkg::ACT_W-1:0]        action,
    input  logic [blg_pkg::SAMPLE_W-1:0]     sample,

    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [blg_pkg::LEVEL_W-1:0]      average_level,
    output logic [blg_pkg::PCT_W-1:0]        held_percent,
    output logic [blg_pkg::WHOLE_W-1:0]      whole_percent,
    output logic                             display_changed,
    output logic [blg_pkg::BAND_W-1:0]       level_band,
    output logic                             in_range
);

`include "battery_level_gauge_core_macros.svh"

    localparam int PW  = $clog2(WINDOW);
    localparam int CW  = $clog2(WINDOW + 1);
    localparam int SW  = $clog2(WINDOW * 1023 + 1);
    localparam int XW  = SW + 6;
    localparam bit POW2 = (WINDOW & (WINDOW - 1)) == 0;
    localparam int SPW = blg_pkg::SAMPLE_W;
    localparam int LVW = blg_pkg::LEVEL_W;
    localparam int PCW = blg_pkg::PCT_W;
    localparam int WHW = blg_pkg::WHOLE_W;
    localparam int ACW = blg_pkg::ACT_W;
    localparam int GNW = blg_pkg::GAIN_W;

    // configuration
    logic [LVW-1:0] dead_reg, full_reg;
    logic [GNW-1:0] gain_reg;
    logic [PCW-1:0] hyst_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dead_reg <= blg_pkg::DEAD_RESET;
            full_reg <= blg_pkg::FULL_RESET;
            gain_reg <= blg_pkg::GAIN_RESET;
            hyst_reg <= blg_pkg::HYST_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                blg_pkg::CFG_DEAD: dead_reg <= cfg_data[LVW-1:0];
                blg_pkg::CFG_FULL: full_reg <= cfg_data[LVW-1:0];
                blg_pkg::CFG_GAIN: gain_reg <= cfg_data[GNW-1:0];
                blg_pkg::CFG_HYST: hyst_reg <= cfg_data[PCW-1:0];
                default: ;
            endcase
        end
    end

    // pipeline flow control
    logic a_v_reg, b_v_reg, c_v_reg, out_v_reg;
    logic out_rdy, c_rdy, b_rdy, a_rdy, accept;

    assign out_rdy  = !out_v_reg || !out_stall;
    assign c_rdy    = !c_v_reg || out_rdy;
    assign b_rdy    = !b_v_reg || c_rdy;
    assign a_rdy    = !a_v_reg || b_rdy;
    assign in_stall = !a_rdy;
    assign accept   = in_valid && a_rdy;

    // window state
    logic [PW-1:0]  pos_reg, pos_next;
    logic [CW-1:0]  count_reg, count_next;
    logic [SPW-1:0] prime_reg, prime_next;
    logic [SW-1:0]  sum_reg, sum_next;
    logic [SPW-1:0] rd_q_reg;
    logic [SPW-1:0] old_sample;
    logic           push, in_rng;
    logic [LVW-1:0] q_level;
    logic [SPW-1:0] store_mem [WINDOW];

    always_comb
    begin
        pos_next   = pos_reg;
        count_next = count_reg;
        prime_next = prime_reg;
        sum_next   = sum_reg;
        push       = 1'b0;
        in_rng     = 1'b0;
        q_level    = {sample, 6'b0};
        old_sample = (count_reg == CW'(WINDOW)) ? rd_q_reg : prime_reg;
        if (accept)
        begin
            case (action)
                blg_pkg::ACT_STORE, blg_pkg::ACT_EVAL:
                begin
                    push     = 1'b1;
                    sum_next = sum_reg - SW'(old_sample) + SW'(sample);
                    pos_next = (pos_reg == PW'(WINDOW - 1)) ? '0 : pos_reg + PW'(1);
                    if (count_reg != CW'(WINDOW))
                        count_next = count_reg + CW'(1);
                end
                blg_pkg::ACT_PRIME:
                begin
                    prime_next = sample;
                    count_next = '0;
                    sum_next   = SW'(sample) * SW'(WINDOW);
                    in_rng     = (q_level > dead_reg) && (q_level < full_reg);
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            store_mem[pos_reg] <= sample;
        rd_q_reg <= store_mem[pos_next];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            count_reg <= '0;
            prime_reg <= '0;
            sum_reg   <= '0;
        end
        else
        begin
            pos_reg   <= pos_next;
            count_reg <= count_next;
            prime_reg <= prime_next;
            sum_reg   <= sum_next;
        end
    end

    // stage a: window sum after the transaction
    logic [ACW-1:0] a_act_reg;
    logic [SW-1:0]  a_sum_reg;
    logic           a_rng_reg;

    always_ff @(posedge clk)
    begin
        if (a_rdy)
        begin
            a_act_reg <= action;
            a_sum_reg <= sum_next;
            a_rng_reg <= in_rng;
        end
    end

    // stage b: window average in q10.6
    logic [LVW-1:0] avg_calc;

    generate
        if (POW2)
        begin : g_avg_shift
            logic [XW-1:0] scaled;
            assign scaled   = {a_sum_reg, 6'b0} >> PW;
            assign avg_calc = scaled[LVW-1:0];
        end
        else
        begin : g_avg_recip
            localparam int K  = XW + PW;
            localparam int MW = XW + 1;
            localparam logic [MW-1:0] RECIP =
                MW'(((64'd1 << K) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));
            logic [XW+MW-1:0] prod;
            assign prod     = (XW+MW)'({a_sum_reg, 6'b0}) * (XW+MW)'(RECIP);
            assign avg_calc = prod[K +: LVW];
        end
    endgenerate

    logic [ACW-1:0] b_act_reg;
    logic [LVW-1:0] b_avg_reg;
    logic           b_rng_reg;

    always_ff @(posedge clk)
    begin
        if (b_rdy)
        begin
            b_act_reg <= a_act_reg;
            b_avg_reg <= avg_calc;
            b_rng_reg <= a_rng_reg;
        end
    end

    // stage c: percent in q7.8
    logic [LVW-1:0]     lvl_diff;
    logic [LVW+GNW-1:0] pct_prod;
    logic [GNW-1:0]     pct_raw;
    logic [PCW-1:0]     pct_calc;

    always_comb
    begin
        lvl_diff = b_avg_reg - dead_reg;
        pct_prod = (LVW+GNW)'(lvl_diff) * (LVW+GNW)'(gain_reg);
        pct_raw  = pct_prod[LVW+GNW-1:16];
        if (b_avg_reg <= dead_reg)
            pct_calc = '0;
        else if (pct_raw > GNW'(blg_pkg::PCT_MAX))
            pct_calc = blg_pkg::PCT_MAX;
        else
            pct_calc = pct_raw[PCW-1:0];
    end

    logic [ACW-1:0] c_act_reg;
    logic [LVW-1:0] c_avg_reg;
    logic [PCW-1:0] c_pct_reg;
    logic           c_rng_reg;

    always_ff @(posedge clk)
    begin
        if (c_rdy)
        begin
            c_act_reg <= b_act_reg;
            c_avg_reg <= b_avg_reg;
            c_pct_reg <= pct_calc;
            c_rng_reg <= b_rng_reg;
        end
    end

    // output stage: hysteresis and reported percent
    logic [PCW-1:0] hold_reg, hold_next;
    logic [WHW-1:0] rep_reg, rep_next;
    logic [PCW-1:0] pct_delta;
    logic [WHW-1:0] whole_calc;
    logic           upd, chg, load_out;

    assign load_out = c_v_reg && out_rdy;

    always_comb
    begin
        pct_delta  = (c_pct_reg >= hold_reg) ? c_pct_reg - hold_reg : hold_reg - c_pct_reg;
        whole_calc = c_pct_reg[PCW-1:8];
        upd        = load_out && (c_act_reg == blg_pkg::ACT_EVAL) && (pct_delta >= hyst_reg);
        chg        = upd && (whole_calc != rep_reg);
        hold_next  = upd ? c_pct_reg : hold_reg;
        rep_next   = chg ? whole_calc : rep_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_reg <= '0;
            rep_reg  <= blg_pkg::WHOLE_NONE;
        end
        else
        begin
            hold_reg <= hold_next;
            rep_reg  <= rep_next;
        end
    end

    logic [LVW-1:0] out_avg_reg;
    logic           out_chg_reg, out_rng_reg;

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_avg_reg <= c_avg_reg;
            out_chg_reg <= chg;
            out_rng_reg <= c_rng_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg   <= 1'b0;
            b_v_reg   <= 1'b0;
            c_v_reg   <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            if (a_rdy)
                a_v_reg <= accept;
            if (b_rdy)
                b_v_reg <= a_v_reg;
            if (c_rdy)
                c_v_reg <= b_v_reg;
            if (out_rdy)
                out_v_reg <= c_v_reg;
        end
    end

    assign out_valid       = out_v_reg;
    assign average_level   = out_avg_reg;
    assign held_percent    = hold_reg;
    assign whole_percent   = rep_reg;
    assign display_changed = out_chg_reg;
    assign level_band      = blg_pkg::band_of(rep_reg);
    assign in_range        = out_rng_reg;

    `BLG_ASSERT_IMP(a_count_bound, 1'b1, count_reg <= CW'(WINDOW))
    `BLG_ASSERT_IMP(a_pos_bound, 1'b1, pos_reg <= PW'(WINDOW - 1))
    `BLG_ASSERT_IMP(a_hold_bound, 1'b1, hold_reg <= blg_pkg::PCT_MAX)
    `BLG_ASSERT_IMP(a_changed_band, out_v_reg && out_chg_reg, level_band != 3'd0)
    `BLG_ASSERT_IMP(a_empty_no_stall, !out_v_reg, !in_stall)
    `BLG_ASSERT_NXT(a_prime_clears, accept && action == blg_pkg::ACT_PRIME, count_reg == '0)

endmodule

/* tb/sv/tb.sv */
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import blg_pkg::*;

    localparam int WIN          = WINDOW_DEFAULT;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 12;

    localparam logic [ACT_W-1:0] ACT_NONE = 2'd3;

    typedef struct packed {
        logic [LEVEL_W-1:0] avg_level;
        logic [PCT_W-1:0]   held_pct;
        logic [WHOLE_W-1:0] whole_pct;
        logic               changed;
        logic [BAND_W-1:0]  band;
        logic               between;
    } gauge_result_t;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [CIDX_W-1:0]   cfg_index = CFG_DEAD;
    logic [CDATA_W-1:0]  cfg_data  = '0;
    logic                in_valid  = 1'b0;
    logic                in_stall;
    logic [ACT_W-1:0]    action    = ACT_STORE;
    logic [SAMPLE_W-1:0] sample    = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [LEVEL_W-1:0]  average_level;
    logic [PCT_W-1:0]    held_percent;
    logic [WHOLE_W-1:0]  whole_percent;
    logic                display_changed;
    logic [BAND_W-1:0]   level_band;
    logic                in_range;

    // gauge state mirrored for prediction
    logic [SAMPLE_W-1:0] window_mem [WIN];
    int unsigned         slot;
    int unsigned         fill_count;
    logic [SAMPLE_W-1:0] prime_level;
    int unsigned         sum_acc;
    logic [PCT_W-1:0]    hold_pct;
    logic [WHOLE_W-1:0]  shown_pct;
    logic [LEVEL_W-1:0]  dead_cfg;
    logic [LEVEL_W-1:0]  full_cfg;
    logic [GAIN_W-1:0]   gain_cfg;
    logic [PCT_W-1:0]    hyst_cfg;

    gauge_result_t expected_results [$];
    int send_idle_pct = 0;
    int stall_pct     = 0;
    int error_count   = 0;
    int cycle_count   = 0;

    battery_level_gauge_core dut (.*);

    initial
    begin
        forever #10 clk = ~clk;
    end

    function automatic logic [LEVEL_W-1:0] window_avg();
        int unsigned a;
        a = (sum_acc * 64) / WIN;
        return a[LEVEL_W-1:0];
    endfunction

    function automatic logic [PCT_W-1:0] charge_percent(input logic [LEVEL_W-1:0] avg);
        logic [47:0] scaled;
        if (avg <= dead_cfg)
            return '0;
        scaled = {32'd0, avg - dead_cfg} * {24'd0, gain_cfg};
        scaled = scaled >> 16;
        if (scaled > PCT_MAX)
            return PCT_MAX;
        return scaled[PCT_W-1:0];
    endfunction

    function automatic logic [BAND_W-1:0] display_band(input logic [WHOLE_W-1:0] whole);
        logic [BAND_W-1:0] b;
        if (whole > WHOLE_MAX)
            return '0;
        b = BAND_W'(whole / 20 + 1);
        if (b > 3'd5)
            b = 3'd5;
        return b;
    endfunction

    function automatic gauge_result_t gauge_step(input logic [ACT_W-1:0] act,
                                                 input logic [SAMPLE_W-1:0] smp);
        gauge_result_t       r;
        logic [SAMPLE_W-1:0] leaving;
        logic [PCT_W-1:0]    pct;
        logic [PCT_W-1:0]    diff;
        logic [LEVEL_W-1:0]  scaled_smp;
        r = '0;
        if (act == ACT_STORE || act == ACT_EVAL)
        begin
            leaving = (fill_count >= WIN) ? window_mem[slot] : prime_level;
            sum_acc = sum_acc - leaving + smp;
            window_mem[slot] = smp;
            slot = (slot + 1 >= WIN) ? 0 : slot + 1;
            if (fill_count < WIN)
                fill_count++;
            if (act == ACT_EVAL)
            begin
                pct  = charge_percent(window_avg());
                diff = (pct >= hold_pct) ? pct - hold_pct : hold_pct - pct;
                if (diff >= hyst_cfg)
                begin
                    hold_pct = pct;
                    if (pct[PCT_W-1:8] != shown_pct)
                    begin
                        shown_pct = pct[PCT_W-1:8];
                        r.changed = 1'b1;
                    end
                end
            end
        end
        else if (act == ACT_PRIME)
        begin
            scaled_smp  = {smp, 6'd0};
            prime_level = smp;
            fill_count  = 0;
            sum_acc     = smp * WIN;
            r.between   = (scaled_smp > dead_cfg) && (scaled_smp < full_cfg);
        end
        r.avg_level = window_avg();
        r.held_pct  = hold_pct;
        r.whole_pct = shown_pct;
        r.band      = display_band(shown_pct);
        return r;
    endfunction

    function automatic void reset_model();
        slot        = 0;
        fill_count  = 0;
        prime_level = '0;
        sum_acc     = 0;
        hold_pct    = '0;
        shown_pct   = WHOLE_NONE;
        dead_cfg    = DEAD_RESET;
        full_cfg    = FULL_RESET;
        gain_cfg    = GAIN_RESET;
        hyst_cfg    = HYST_RESET;
    endfunction

    function automatic void note_error(input string what, input longint want,
                                       input longint got);
        error_count++;
        if (error_count <= 10)
            $display("tb: mismatch on %s: expected %0d, got %0d", what, want, got);
    endfunction

    // result checking
    always @(posedge clk)
    begin
        gauge_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_results.size() == 0)
                note_error("unexpected transaction", 0, 1);
            else
            begin
                want = expected_results.pop_front();
                if (average_level !== want.avg_level)
                    note_error("average_level", want.avg_level, average_level);
                if (held_percent !== want.held_pct)
                    note_error("held_percent", want.held_pct, held_percent);
                if (whole_percent !== want.whole_pct)
                    note_error("whole_percent", want.whole_pct, whole_percent);
                if (display_changed !== want.changed)
                    note_error("display_changed", want.changed, display_changed);
                if (level_band !== want.band)
                    note_error("level_band", want.band, level_band);
                if (in_range !== want.between)
                    note_error("in_range", want.between, in_range);
            end
        end
    end

    always @(posedge clk)
        out_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb: done, errors");
        $finish;
    end

    task automatic send_item(input logic [ACT_W-1:0] act, input logic [SAMPLE_W-1:0] smp);
        while ((send_idle_pct > 0) && ($urandom_range(99) < send_idle_pct))
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        action   <= act;
        sample   <= smp;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        expected_results.push_back(gauge_step(act, smp));
    endtask

    // sender holds off until every outstanding transaction has come back
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CDATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_DEAD: dead_cfg = val[LEVEL_W-1:0];
            CFG_FULL: full_cfg = val[LEVEL_W-1:0];
            CFG_GAIN: gain_cfg = val[GAIN_W-1:0];
            CFG_HYST: hyst_cfg = val[PCT_W-1:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic program_gauge(input logic [LEVEL_W-1:0] dead, input logic [LEVEL_W-1:0] full,
                                 input logic [GAIN_W-1:0] gain, input logic [PCT_W-1:0] hyst);
        write_reg(CFG_DEAD, {8'd0, dead});
        write_reg(CFG_FULL, {8'd0, full});
        write_reg(CFG_GAIN, gain);
        write_reg(CFG_HYST, {9'd0, hyst});
    endtask

    // gain sized to the span so that full maps to 100%
    task automatic program_realistic();
        int unsigned dead;
        int unsigned span;
        dead = $urandom_range(56000, 40000);
        span = $urandom_range(9000, 2000);
        program_gauge(LEVEL_W'(dead), LEVEL_W'(dead + span), GAIN_W'(1677721600 / span),
                      PCT_W'($urandom_range(400)));
    endtask

    // battery level drifts slowly, with noise and occasional wild readings
    task automatic run_samples(input int count);
        int               level;
        int               heading;
        int               smp;
        int               pick;
        logic [ACT_W-1:0] act;
        level   = ((int'(dead_cfg) + int'(full_cfg)) / 2) >> 6;
        heading = 1;
        repeat (count)
        begin
            if ($urandom_range(49) == 0)
                heading = -heading;
            level += heading * int'($urandom_range(2));
            if (level < 0)
            begin
                level   = 0;
                heading = 1;
            end
            if (level > 1023)
            begin
                level   = 1023;
                heading = -1;
            end
            if ($urandom_range(3) == 0)
                smp = $urandom_range(1023);
            else
                smp = level + int'($urandom_range(16)) - 8;
            if (smp < 0)
                smp = 0;
            if (smp > 1023)
                smp = 1023;
            pick = $urandom_range(999);
            if (pick < 6)
                act = ACT_PRIME;
            else if (pick < 20)
                act = ACT_NONE;
            else if (pick < 520)
                act = ACT_EVAL;
            else
                act = ACT_STORE;
            send_item(act, smp[SAMPLE_W-1:0]);
        end
    endtask

    task automatic test_reset_defaults();
        send_item(ACT_EVAL, 10'd0);
        send_item(ACT_NONE, 10'd1023);
        send_item(ACT_PRIME, 10'd1023);
        send_item(ACT_EVAL, 10'd1023);
        send_item(ACT_STORE, 10'd0);
        send_item(ACT_PRIME, 10'd830);
        send_item(ACT_PRIME, 10'd831);
        send_item(ACT_EVAL, 10'd831);
        send_item(ACT_PRIME, 10'd945);
        send_item(ACT_PRIME, 10'd946);
        send_item(ACT_EVAL, 10'd946);
        send_item(ACT_PRIME, 10'd0);
        send_item(ACT_EVAL, 10'd0);
        send_item(ACT_STORE, 10'd1023);
        settle();
    endtask

    task automatic test_hysteresis_bounds();
        // average landing exactly on the empty level, step of zero
        program_gauge(16'd57600, FULL_RESET, GAIN_RESET, 15'd0);
        send_item(ACT_EVAL, 10'd0);
        send_item(ACT_PRIME, 10'd900);
        send_item(ACT_EVAL, 10'd900);
        send_item(ACT_PRIME, 10'd901);
        send_item(ACT_EVAL, 10'd901);
        send_item(ACT_PRIME, 10'd0);
        send_item(ACT_EVAL, 10'd0);
        settle();
        // full-scale swing equal to the largest step
        write_reg(CFG_HYST, {9'd0, PCT_MAX});
        send_item(ACT_PRIME, 10'd1023);
        send_item(ACT_EVAL, 10'd1023);
        send_item(ACT_PRIME, 10'd600);
        send_item(ACT_EVAL, 10'd600);
        settle();
    endtask

    task automatic test_steady_stream();
        send_idle_pct = 0;
        stall_pct     = 0;
        program_realistic();
        run_samples(200);
        settle();
    endtask

    task automatic test_extreme_levels_sender_gaps();
        program_gauge(16'd0, 16'hFFFF, 24'hFFFFFF, 15'd0);
        send_idle_pct = 63;
        stall_pct     = 0;
        run_samples(200);
        settle();
    endtask

    task automatic test_inverted_levels_receiver_stalls();
        program_gauge(16'hFFFF, 16'd0, 24'd0, PCT_MAX);
        send_idle_pct = 0;
        stall_pct     = 63;
        run_samples(200);
        settle();
    endtask

    task automatic test_mixed_idling();
        send_idle_pct = 0;
        stall_pct     = 0;
        program_realistic();
        send_idle_pct = 9;
        stall_pct     = 9;
        run_samples(200);
        settle();
    endtask

    initial
    begin
        reset_model();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_hysteresis_bounds();
        test_steady_stream();
        test_extreme_levels_sender_gaps();
        test_inverted_levels_receiver_stalls();
        test_mixed_idling();
        stall_pct = 0;
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0 && expected_results.size() == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+hdl
hdl/blg_pkg.sv
hdl/battery_level_gauge_core.sv
tb/sv/tb.sv
